// File: rtl/shs_pkg.sv
// Shared types and constants of the SHA-256 stream hasher.
package shs_pkg;

  localparam int unsigned COUNT_W = 61;
  localparam int unsigned LEN_W   = 64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t H_INIT = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  typedef enum logic [2:0] {
    WIN_NONE,
    WIN_BYTE,
    WIN_PAD,
    WIN_PAD_LEN,
    WIN_LEN
  } win_op_t;

  typedef struct packed {
    win_op_t          op;
    logic             start;
    logic             init;
    logic [5:0]       pos;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } core_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

// File: rtl/shs_stream_if.sv
// Valid/ready channels for message bytes and digest words.
interface shs_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source(output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface shs_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        too_long;
  logic        last_word;

  modport source(output valid, digest_word, word_index, too_long, last_word, input ready);
  modport sink(input valid, digest_word, word_index, too_long, last_word, output ready);
endinterface

// File: rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte intake, padding sequencer, digest output.
//
//  channel   dir  handshake     payload
//  message   in   valid/ready   data_byte[7:0], has_byte, end_of_message
//  digest    out  valid/ready   digest_word[31:0], word_index[2:0], too_long, last_word
//
// The item that fills a 64-byte block starts a compression (64 rounds in the shared
// round unit plus one hash add), during which message.ready is low. The end mark adds
// a padding step and a compression, or also a length step and a second compression
// when eight or fewer bytes of the block are left free. Then the eight digest words go
// out one per accepted item; digest stalls hold them.
// rst is synchronous: it clears the sequencer, counters and restores the initial hash.
module sha256_stream_hasher (
  input  logic      clk,
  input  logic      rst,
  shs_msg_if.sink   message,
  shs_dig_if.source digest
);
  import shs_pkg::*;

  typedef enum logic [2:0] {T_IDLE, T_RUN, T_PAD, T_LEN, T_OUT} tstate_t;
  typedef enum logic [1:0] {AFT_IDLE, AFT_PAD, AFT_LEN, AFT_OUT} after_t;

  localparam logic [2:0] LAST_WORD = 3'd7;

  tstate_t           tstate;
  after_t            after;
  logic [COUNT_W-1:0] byte_count;
  logic              length_overflow;
  logic [2:0]        word_idx;
  core_cmd_t         cmd;
  core_stat_t        stat;
  hash_t             hash;
  logic              msg_acc;
  logic              dig_acc;
  logic              at_max;
  logic              block_full;

  assign msg_acc    = message.valid && message.ready;
  assign dig_acc    = digest.valid && digest.ready;
  assign at_max     = (byte_count == COUNT_MAX);
  // The incoming byte completes the current block.
  assign block_full = message.has_byte && !at_max && (byte_count[5:0] == LAST_POS);

  assign message.ready = (tstate == T_IDLE);

  assign digest.valid       = (tstate == T_OUT);
  assign digest.digest_word = hash[word_idx];
  assign digest.word_index  = word_idx;
  assign digest.too_long    = length_overflow;
  assign digest.last_word   = (word_idx == LAST_WORD);

  // Commands to the round unit: window writes, round start, hash reload.
  always_comb begin
    cmd       = '0;
    cmd.op    = WIN_NONE;
    cmd.pos   = byte_count[5:0];
    cmd.data  = message.data_byte;
    cmd.len   = {byte_count, 3'b000};
    unique case (tstate)
      T_IDLE: begin
        if (msg_acc && message.has_byte && !at_max) begin
          cmd.op    = WIN_BYTE;
          cmd.start = block_full;
        end
      end
      T_PAD: begin
        cmd.op    = (byte_count[5:0] >= LEN_POS) ? WIN_PAD : WIN_PAD_LEN;
        cmd.start = 1'b1;
      end
      T_LEN: begin
        cmd.op    = WIN_LEN;
        cmd.start = 1'b1;
      end
      T_OUT: cmd.init = dig_acc && (word_idx == LAST_WORD);
      T_RUN: ;
      default: ;
    endcase
  end

  shs_compress u_compress (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .hash (hash)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate          <= T_IDLE;
      after           <= AFT_IDLE;
      byte_count      <= '0;
      length_overflow <= 1'b0;
      word_idx        <= '0;
    end else begin
      unique case (tstate)
        T_IDLE: begin
          if (msg_acc) begin
            if (message.has_byte) begin
              // Saturate the count and drop the byte once the length is unencodable.
              if (at_max) begin
                length_overflow <= 1'b1;
              end else begin
                byte_count <= byte_count + COUNT_W'(1);
              end
            end
            if (block_full) begin
              tstate <= T_RUN;
              after  <= message.end_of_message ? AFT_PAD : AFT_IDLE;
            end else if (message.end_of_message) begin
              tstate <= T_PAD;
            end
          end
        end
        T_RUN: begin
          if (stat.done) begin
            unique case (after)
              AFT_IDLE: tstate <= T_IDLE;
              AFT_PAD:  tstate <= T_PAD;
              AFT_LEN:  tstate <= T_LEN;
              AFT_OUT:  tstate <= T_OUT;
              default:  tstate <= T_IDLE;
            endcase
          end
        end
        T_PAD: begin
          // No room for the length: it goes in a block of its own.
          tstate <= T_RUN;
          after  <= (byte_count[5:0] >= LEN_POS) ? AFT_LEN : AFT_OUT;
        end
        T_LEN: begin
          tstate <= T_RUN;
          after  <= AFT_OUT;
        end
        T_OUT: begin
          if (dig_acc) begin
            word_idx <= word_idx + 3'd1;
            if (word_idx == LAST_WORD) begin
              byte_count      <= '0;
              length_overflow <= 1'b0;
              tstate          <= T_IDLE;
            end
          end
        end
        default: tstate <= T_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(message.ready && digest.valid)) else $error("intake open during digest output");
  a_msg_clear: assert property (@(posedge clk) disable iff (rst)
    (dig_acc && digest.last_word) |=> (byte_count == '0 && !length_overflow))
    else $error("message state not cleared after digest");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (dig_acc && !digest.last_word) |=> digest.word_index == $past(digest.word_index) + 3'd1)
    else $error("digest word index skipped");
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !stat.busy) else $error("round unit started while busy");

endmodule

// File: rtl/shs_compress.sv
// Iterative SHA-256 compression: one round per cycle over a 16-word window.
module shs_compress (
  input  logic               clk,
  input  logic               rst,
  input  shs_pkg::core_cmd_t  cmd,
  output shs_pkg::core_stat_t stat,
  output shs_pkg::hash_t      hash
);
  import shs_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  cstate_t          cstate;
  logic [5:0]       rnd;
  hash_t            wv;
  hash_t            hash_sum;
  logic [15:0][31:0] win;
  logic [15:0][31:0] win_pad;
  logic [15:0][31:0] win_pad_len;
  logic [15:0][31:0] win_len;
  logic [31:0]      w_sched;
  logic [31:0]      w_cur;
  logic [31:0]      s0_w;
  logic [31:0]      s1_w;
  logic [31:0]      t1;
  logic [31:0]      t2;

  // Message schedule: window holds W[r-16] .. W[r-1], oldest at index 0.
  assign s0_w    = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
  assign s1_w    = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
  assign w_sched = s1_w + win[9] + s0_w + win[0];
  assign w_cur   = (rnd[5:4] == 2'b00) ? win[0] : w_sched;

  assign t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
            + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + K_TABLE[rnd] + w_cur;
  assign t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
            + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));

  // Padding: keep bytes before the fill position, mark it, zero the rest.
  always_comb begin
    win_pad = win;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == cmd.pos) begin
        win_pad[i / 4][(3 - (i % 4)) * 8 +: 8] = PAD_BYTE;
      end else if (6'(i) > cmd.pos) begin
        win_pad[i / 4][(3 - (i % 4)) * 8 +: 8] = 8'h00;
      end
    end
    // Bit length in the last two words, with or without the padded tail.
    win_pad_len     = win_pad;
    win_pad_len[14] = cmd.len[63:32];
    win_pad_len[15] = cmd.len[31:0];
    win_len         = '0;
    win_len[14]     = cmd.len[63:32];
    win_len[15]     = cmd.len[31:0];
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_sum[i] = hash[i] + wv[i];
    end
  end

  assign stat = {cstate != C_IDLE, cstate == C_ADD};

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
      rnd    <= '0;
      hash   <= H_INIT;
    end else begin
      unique case (cstate)
        C_IDLE: begin
          if (cmd.init) begin
            hash <= H_INIT;
          end
          if (cmd.start) begin
            wv     <= hash;
            rnd    <= '0;
            cstate <= C_ROUND;
          end
        end
        C_ROUND: begin
          wv     <= {wv[6], wv[5], wv[4], wv[3] + t1, wv[2], wv[1], wv[0], t1 + t2};
          win    <= {w_cur, win[15:1]};
          rnd    <= rnd + 6'd1;
          if (rnd == LAST_POS) begin
            cstate <= C_ADD;
          end
        end
        C_ADD: begin
          hash   <= hash_sum;
          rnd    <= '0;
          cstate <= C_IDLE;
        end
        default: cstate <= C_IDLE;
      endcase

      if (cstate != C_ROUND) begin
        unique case (cmd.op)
          WIN_NONE: ;
          WIN_BYTE: win[cmd.pos[5:2]][{~cmd.pos[1:0], 3'b000} +: 8] <= cmd.data;
          WIN_PAD:  win <= win_pad;
          WIN_PAD_LEN: win <= win_pad_len;
          WIN_LEN:  win <= win_len;
          default: ;
        endcase
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> cstate == C_IDLE) else $error("start while compressing");
  a_round_len: assert property (@(posedge clk) disable iff (rst)
    (cstate == C_ROUND && rnd == LAST_POS) |=> cstate == C_ADD)
    else $error("round count did not end in hash add");
  a_idle_rnd: assert property (@(posedge clk) disable iff (rst)
    cstate == C_IDLE |-> rnd == 6'd0) else $error("round counter not clear in idle");

endmodule

// File: tb/sv/tb_sha256_stream_hasher.sv
// Self-checking testbench for the SHA-256 stream hasher.
module tb_sha256_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD = 400;

  // SHA-256 initial chaining value and round constants, word 0 leftmost.
  localparam logic [0:7][31:0] HASH_IV = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // One digest word as the block should return it.
  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        too_long;
    logic        last_word;
  } digest_word_t;

  logic clk;
  logic rst;

  shs_msg_if message_ch ();
  shs_dig_if digest_ch ();

  sha256_stream_hasher dut (
    .clk     (clk),
    .rst     (rst),
    .message (message_ch),
    .digest  (digest_ch)
  );

  // Predictor state: chaining hash, partial block, running length.
  logic [31:0]                 chain_hash [8];
  logic [7:0]                  msg_block [64];
  logic [shs_pkg::COUNT_W-1:0] msg_bytes;
  logic                        len_overflow;

  digest_word_t expected_digest [$];

  int  mismatch_count;
  int  cycle_count;
  int  items_sent;
  bit  idle_on;
  int  hold_request;

  // --------------------------------------------------------------------------
  // Reference SHA-256 arithmetic
  // --------------------------------------------------------------------------

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // Run the 64 rounds over msg_block and fold the result into chain_hash.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
    e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
           ROUND_K[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
    chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++)
      chain_hash[i] = HASH_IV[i];
    msg_bytes    = '0;
    len_overflow = 1'b0;
  endfunction

  // Absorb one accepted item; on the end mark pad, finish and queue the digest.
  function automatic void absorb_item(input logic [7:0] b, input logic hb, input logic eom);
    logic [5:0]   fill;
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (hb) begin
      if (msg_bytes == shs_pkg::COUNT_MAX) begin
        // saturated length: drop the byte and flag the message
        len_overflow = 1'b1;
      end else begin
        msg_block[msg_bytes[5:0]] = b;
        msg_bytes++;
        if (msg_bytes[5:0] == 6'd0)
          compress_block();
      end
    end
    if (!eom)
      return;
    fill = msg_bytes[5:0];
    msg_block[fill] = shs_pkg::PAD_BYTE;
    for (int i = int'(fill) + 1; i < 64; i++)
      msg_block[i] = 8'h00;
    // no room left for the length field: spend an extra block
    if (fill >= shs_pkg::LEN_POS) begin
      compress_block();
      for (int i = 0; i < 64; i++)
        msg_block[i] = 8'h00;
    end
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++)
      msg_block[shs_pkg::LEN_POS + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      dw.digest_word = chain_hash[i];
      dw.word_index  = 3'(i);
      dw.too_long    = len_overflow;
      dw.last_word   = (i == 7);
      expected_digest = {expected_digest, dw};
    end
    restart_message();
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Digest side: random stalls, long hold on request, and checking
  // --------------------------------------------------------------------------

  initial begin
    int hold_left;
    int stall_left;
    digest_word_t want;
    hold_left  = 0;
    stall_left = 0;
    digest_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      // Check the item taken at this edge against the oldest prediction.
      if (!rst && digest_ch.valid && digest_ch.ready) begin
        if (expected_digest.size() == 0) begin
          $error("unexpected digest item: digest_word %h word_index %0d",
                 digest_ch.digest_word, digest_ch.word_index);
          mismatch_count++;
        end else begin
          want = expected_digest.pop_front();
          if (digest_ch.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word,
                   digest_ch.digest_word);
            mismatch_count++;
          end
          if (digest_ch.word_index !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index,
                   digest_ch.word_index);
            mismatch_count++;
          end
          if (digest_ch.too_long !== want.too_long) begin
            $error("too_long: expected %0b, got %0b", want.too_long, digest_ch.too_long);
            mismatch_count++;
          end
          if (digest_ch.last_word !== want.last_word) begin
            $error("last_word: expected %0b, got %0b", want.last_word,
                   digest_ch.last_word);
            mismatch_count++;
          end
        end
      end
      // Pick up a long hold-off request, counted here in cycles.
      if (hold_left == 0 && hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      // Decide ready for the next edge: exactly one drive per step.
      if (hold_left > 0) begin
        hold_left--;
        digest_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        digest_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        digest_ch.ready <= 1'b0;
      end else begin
        digest_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Message side: shared send task and helpers
  // --------------------------------------------------------------------------

  // Offer one item, hold it until taken, then feed it to the predictor.
  task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      message_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    message_ch.valid          <= 1'b1;
    message_ch.data_byte      <= b;
    message_ch.has_byte       <= hb;
    message_ch.end_of_message <= eom;
    do @(posedge clk); while (message_ch.ready !== 1'b1);
    absorb_item(b, hb, eom);
    if (hb || eom)
      items_sent++;
  endtask

  // Send a message of random bytes; close it on the last byte or with a bare
  // end mark. Sprinkle in items that carry neither a byte nor an end.
  task automatic send_message(input int len, input bit separate_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !separate_end && i == len - 1);
    end
    if (separate_end || len == 0)
      send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Drop valid and wait until every predicted digest word has come back.
  task automatic wait_drained();
    message_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_digest.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hash of the empty message: an end mark with no byte.
  task automatic test_empty_message();
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  // An item with neither byte nor end must leave the message untouched.
  task automatic test_ignored_item();
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  // End mark on its own item after a few bytes.
  task automatic test_end_mark_alone();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
  endtask

  // Byte extremes, with the end mark riding on the last byte.
  task automatic test_byte_extremes();
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
  endtask

  // Fills around the padding boundaries: one final block, two final blocks,
  // and an exactly full block before the end.
  task automatic test_block_boundaries();
    send_message(55, 1'($urandom_range(0, 1)));
    send_message(56, 1'($urandom_range(0, 1)));
    send_message(63, 1'($urandom_range(0, 1)));
    send_message(64, 1'($urandom_range(0, 1)));
  endtask

  // Random well-formed messages, mostly short, some spanning blocks.
  task automatic test_random_messages(input int target);
    int stop_at;
    int len;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7)
        len = $urandom_range(0, 20);
      else
        len = $urandom_range(21, 135);
      send_message(len, $urandom_range(0, 2) == 0);
    end
  endtask

  // Hold the digest side off for a long stretch while short messages keep
  // coming, so the block backs up and stalls its input; then pause the
  // sender until the whole backlog has drained.
  task automatic test_output_backpressure();
    hold_request = LONG_HOLD;
    repeat (5) send_message($urandom_range(0, 3), 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_messages(20);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    items_sent     = 0;
    hold_request   = 0;
    idle_on        = 1'b1;
    restart_message();
    for (int i = 0; i < 64; i++)
      msg_block[i] = 8'h00;
    message_ch.valid          = 1'b0;
    message_ch.data_byte      = 8'h00;
    message_ch.has_byte       = 1'b0;
    message_ch.end_of_message = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_message();
    test_ignored_item();
    test_end_mark_alone();
    test_byte_extremes();
    test_block_boundaries();
    test_random_messages(30);
    test_output_backpressure();
    test_random_messages(20);
    test_full_rate();

    // Let every outstanding digest arrive, then watch for stray output.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_digest.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
